### rtl/core/assert_macros.svh
// Assertion macros shared by the thinning RTL.
// No dependencies; expects aclk and aresetn in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define BTP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("btp assertion failed");

// Next-cycle implication, checked while out of reset
`define BTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("btp assertion failed");

`endif

### rtl/core/btp_pkg.sv
// Constants, register indexes and the neighborhood test for the thinning pass.
// No dependencies.
package btp_pkg;

    localparam int PIXEL_W   = 8;
    localparam int COUNT_W   = 22;
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 12;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd50;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd42;

    localparam int MIN_DIM = 3;   // smallest usable width or height
    localparam int BORDER  = 2;   // first interior row/column, one behind input
    localparam logic [PIXEL_W-1:0] FULL_PIXEL = 8'd255;
    localparam logic [3:0] B_MIN = 4'd2;
    localparam logic [3:0] B_MAX = 4'd6;

    // ring bits in order N, NE, E, SE, S, SW, W, NW (bit 0 = N)
    typedef logic [7:0] ring_t;

    // One pass of both sub-iteration tests ORed together
    function automatic logic thin_test(input ring_t ring);
        logic [3:0] a;
        logic [3:0] b;
        logic       n;
        logic       e;
        logic       s;
        logic       w;
        logic       base;
        logic       first;
        logic       second;
        a = '0;
        b = '0;
        for (int i = 0; i < 8; i++) begin
            a = a + 4'((!ring[i]) && ring[(i + 1) % 8]);
            b = b + 4'(ring[i]);
        end
        n = ring[0];
        e = ring[2];
        s = ring[4];
        w = ring[6];
        base   = (a == 4'd1) && (b >= B_MIN) && (b <= B_MAX);
        first  = base && !(n && e && s) && !(e && s && w);
        second = base && !(n && e && w) && !(n && s && w);
        return first || second;
    endfunction

endpackage

### rtl/core/binary_thinning_pass_unit.sv
// Top level of the binary thinning pass: line stores, 3x3 window, decision, output register.
// Depends on btp_pkg and assert_macros.svh.
//
// Takes one 8-bit pixel per clock in raster order. In the cycle after the pixel that
// completes its neighborhood, it returns the updated value of each interior pixel
// (one row and one column behind the input). A set pixel of 255 that passes the
// two thinning sub-iteration tests (ORed) comes out as 0 with deleted high and the
// frame's running deletion count. Border pixels give no result. Throughput is one
// pixel per cycle, with the result registered. The input stalls only while a result
// waits on m_ready. The two line stores are MAX_WIDTH-deep arrays, each read at the
// next column in every cycle with registered read data and written at the current one
// when a pixel is accepted. They are not cleared after reset; the first two rows of a
// frame fill them. Width and height come from the configuration port (index 0 and
// 1). Width is clamped to [3, MAX_WIDTH] and height to at least 3. A write takes
// effect at the next item and keeps the frame position, so write between frames
// or, for the width, at a row boundary. Both ready outputs are low during reset.
`include "assert_macros.svh"

module binary_thinning_pass_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [btp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [btp_pkg::CFG_DATA_W-1:0]  cfg_data,
    // pixel input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [btp_pkg::PIXEL_W-1:0]     s_pixel,
    // result output
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [btp_pkg::PIXEL_W-1:0]     m_new_value,
    output logic                            m_deleted,
    output logic [btp_pkg::COUNT_W-1:0]     m_deleted_count,
    output logic                            m_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = ($clog2(MAX_WIDTH + 1) > btp_pkg::WIDTH_W) ?
                        $clog2(MAX_WIDTH + 1) : btp_pkg::WIDTH_W;
    localparam int HW = btp_pkg::HEIGHT_W;
    localparam int PW = btp_pkg::PIXEL_W;

    // configuration registers
    logic [btp_pkg::WIDTH_W-1:0] width_reg;
    logic [HW-1:0]               height_reg;

    // frame position and deletion count
    logic [CW-1:0]                col_reg,   col_next;
    logic [HW-1:0]                row_reg,   row_next;
    logic [btp_pkg::COUNT_W-1:0]  total_reg, total_next;

    // line stores and their registered read data
    logic [PW-1:0] top_mem [MAX_WIDTH];
    logic [PW-1:0] mid_mem [MAX_WIDTH];
    logic [PW-1:0] top_rd_reg;
    logic [PW-1:0] mid_rd_reg;

    // window columns 1 and 2 (rows 0..2); column 0 is never needed after a shift
    logic [PW-1:0] win1_reg [3];
    logic [PW-1:0] win2_reg [3];

    // output register
    logic                         m_valid_reg;
    logic [PW-1:0]                m_new_value_reg;
    logic                         m_deleted_reg;
    logic [btp_pkg::COUNT_W-1:0]  m_count_reg;
    logic                         m_last_reg;

    logic                         in_acc;
    logic [EW-1:0]                eff_w;
    logic [HW-1:0]                eff_h;
    logic [EW-1:0]                col_ext;
    logic [EW-1:0]                col_inc;
    logic [HW:0]                  row_inc;
    logic                         row_wrap;
    logic                         frame_end;
    logic                         emit;
    logic                         is_last;
    logic                         del;
    btp_pkg::ring_t               ring;
    logic [PW-1:0]                centre;
    logic [btp_pkg::COUNT_W-1:0]  count_out;

    assign cfg_ready = aresetn;
    assign s_ready   = aresetn && (!m_valid_reg || m_ready);
    assign in_acc    = s_valid && s_ready;

    // effective image size
    always_comb begin
        logic [EW-1:0] w_ext;
        w_ext = EW'(width_reg);
        if (w_ext < EW'(btp_pkg::MIN_DIM)) begin
            eff_w = EW'(btp_pkg::MIN_DIM);
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = w_ext;
        end
        eff_h = (height_reg < HW'(btp_pkg::MIN_DIM)) ? HW'(btp_pkg::MIN_DIM) : height_reg;
    end

    // position stepping
    always_comb begin
        col_ext   = EW'(col_reg);
        col_inc   = col_ext + EW'(1);
        row_inc   = {1'b0, row_reg} + (HW + 1)'(1);
        row_wrap  = col_inc >= eff_w;
        frame_end = row_wrap && (row_inc >= {1'b0, eff_h});
        col_next  = col_reg;
        row_next  = row_reg;
        if (in_acc) begin
            if (row_wrap) begin
                col_next = '0;
                row_next = frame_end ? '0 : row_inc[HW-1:0];
            end else begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    // neighborhood of the center after this item's shift
    always_comb begin
        ring[0] = win2_reg[0] != '0;   // N
        ring[1] = top_rd_reg  != '0;   // NE
        ring[2] = mid_rd_reg  != '0;   // E
        ring[3] = s_pixel     != '0;   // SE
        ring[4] = win2_reg[2] != '0;   // S
        ring[5] = win1_reg[2] != '0;   // SW
        ring[6] = win1_reg[1] != '0;   // W
        ring[7] = win1_reg[0] != '0;   // NW
        centre  = win2_reg[1];
        emit    = (row_reg >= HW'(btp_pkg::BORDER)) && (row_reg < eff_h) &&
                  (col_ext >= EW'(btp_pkg::BORDER)) && (col_ext < eff_w);
        is_last = (row_reg == (eff_h - HW'(1))) && (col_ext == (eff_w - EW'(1)));
        del     = btp_pkg::thin_test(ring) && (centre == btp_pkg::FULL_PIXEL);
        count_out = total_reg + btp_pkg::COUNT_W'(del);
        total_next = total_reg;
        if (in_acc) begin
            if (frame_end) begin
                total_next = '0;
            end else if (emit) begin
                total_next = count_out;
            end
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= btp_pkg::WIDTH_RESET;
            height_reg <= btp_pkg::HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                btp_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[btp_pkg::WIDTH_W-1:0];
                btp_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    // position, count and window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            total_reg <= '0;
            for (int r = 0; r < 3; r++) begin
                win1_reg[r] <= '0;
                win2_reg[r] <= '0;
            end
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            total_reg <= total_next;
            if (in_acc) begin
                for (int r = 0; r < 3; r++) begin
                    win1_reg[r] <= win2_reg[r];
                end
                win2_reg[0] <= top_rd_reg;
                win2_reg[1] <= mid_rd_reg;
                win2_reg[2] <= s_pixel;
            end
        end
    end

    // line stores: write current column, prefetch the next one
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            top_mem[col_reg] <= mid_rd_reg;
            mid_mem[col_reg] <= s_pixel;
        end
        top_rd_reg <= top_mem[col_next];
        mid_rd_reg <= mid_mem[col_next];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= in_acc && emit;
        end
        if (in_acc && emit) begin
            m_new_value_reg <= del ? '0 : centre;
            m_deleted_reg   <= del;
            m_count_reg     <= count_out;
            m_last_reg      <= is_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_new_value     = m_new_value_reg;
    assign m_deleted       = m_deleted_reg;
    assign m_deleted_count = m_count_reg;
    assign m_last          = m_last_reg;

    // checks
    `BTP_ASSERT_NOW(a_deleted_is_zero, m_valid && m_deleted, m_new_value == '0)
    `BTP_ASSERT_NOW(a_col_in_store, 1'b1, EW'(col_reg) < EW'(MAX_WIDTH))
    `BTP_ASSERT_NOW(a_stall_only_when_full, !s_ready, m_valid_reg && !m_ready)
    `BTP_ASSERT_NEXT(a_last_wraps_frame, in_acc && emit && is_last,
        row_reg == '0 && col_reg == '0 && total_reg == '0)

endmodule

### sim/tb_binary_thinning_pass_unit.sv
// Self-checking testbench for binary_thinning_pass_unit: whole frames in, thinned pixels out.
// Depends on btp_pkg and the RTL of the thinning pass; predicts every result on its own.
`timescale 1ns / 1ps

module tb_binary_thinning_pass_unit;

    localparam int MAX_W        = 1024;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 120;
    localparam int IDLE_PCT     = 27;

    localparam int PW    = btp_pkg::PIXEL_W;
    localparam int CNT_W = btp_pkg::COUNT_W;
    localparam int CIW   = btp_pkg::CFG_IDX_W;
    localparam int CDW   = btp_pkg::CFG_DATA_W;
    localparam logic [PW-1:0] FULL = btp_pkg::FULL_PIXEL;

    typedef enum logic [1:0] {FRAME_SHAPES, FRAME_SPARSE, FRAME_NOISE} frame_kind_t;

    typedef struct packed {
        logic [PW-1:0]    value;
        logic             deleted;
        logic [CNT_W-1:0] count;
        logic             last;
    } thin_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CIW-1:0]   cfg_index = btp_pkg::REG_IMAGE_WIDTH;
    logic [CDW-1:0]   cfg_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [PW-1:0]    s_pixel = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [PW-1:0]    m_new_value;
    logic             m_deleted;
    logic [CNT_W-1:0] m_deleted_count;
    logic             m_last;

    // predictor state
    logic [PW-1:0]                    line_mem [2*MAX_W];
    logic [PW-1:0]                    win [3][3];
    logic [btp_pkg::WIDTH_W-1:0]      width_reg = btp_pkg::WIDTH_RESET;
    logic [btp_pkg::HEIGHT_W-1:0]     height_reg = btp_pkg::HEIGHT_RESET;
    int unsigned                      row_pos = 0;
    int unsigned                      col_pos = 0;
    logic [CNT_W-1:0]                 del_total = '0;

    thin_result_t pending_results[$];
    int unsigned  error_count = 0;
    int unsigned  pixels_sent = 0;
    int unsigned  stall_cycles = 0;
    logic         steady = 1'b0;

    binary_thinning_pass_unit #(.MAX_WIDTH(MAX_W)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_new_value     (m_new_value),
        .m_deleted       (m_deleted),
        .m_deleted_count (m_deleted_count),
        .m_last          (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Clamped geometry as the block applies it
    function automatic int unsigned eff_width();
        if (width_reg < btp_pkg::MIN_DIM) return btp_pkg::MIN_DIM;
        if (width_reg > MAX_W) return MAX_W;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg < btp_pkg::MIN_DIM) ? btp_pkg::MIN_DIM : 32'(height_reg);
    endfunction

    // Advance the window by one pixel and queue the result for the interior center
    task automatic thin_pixel(input logic [PW-1:0] px);
        int unsigned   w;
        int unsigned   h;
        int unsigned   addr;
        int unsigned   a;
        int unsigned   b;
        logic [PW-1:0] top;
        logic [PW-1:0] mid;
        logic [7:0]    ring;
        logic          n;
        logic          e;
        logic          s;
        logic          wv;
        logic          base;
        logic          del;
        thin_result_t  r;
        w = eff_width();
        h = eff_height();
        addr = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
        top = line_mem[MAX_W + addr];
        mid = line_mem[addr];
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = px;
        line_mem[MAX_W + addr] = mid;
        line_mem[addr] = px;
        if (row_pos >= btp_pkg::BORDER && row_pos < h &&
            col_pos >= btp_pkg::BORDER && col_pos < w) begin
            // ring from bit 0 upward: N, NE, E, SE, S, SW, W, NW
            ring = {win[0][0] != 0, win[1][0] != 0, win[2][0] != 0, win[2][1] != 0,
                    win[2][2] != 0, win[1][2] != 0, win[0][2] != 0, win[0][1] != 0};
            // a zero followed by a one, walking the ring
            a = $countones(~ring & {ring[0], ring[7:1]});
            b = $countones(ring);
            n = ring[0];
            e = ring[2];
            s = ring[4];
            wv = ring[6];
            base = (a == 1) && (b >= btp_pkg::B_MIN) && (b <= btp_pkg::B_MAX);
            del = base && (win[1][1] == FULL) &&
                  ((!(n && e && s) && !(e && s && wv)) || (!(n && e && wv) && !(n && s && wv)));
            if (del) del_total = del_total + 1'b1;
            r.value = del ? '0 : win[1][1];
            r.deleted = del;
            r.count = del_total;
            r.last = (row_pos == h - 1) && (col_pos == w - 1);
            pending_results.push_back(r);
        end
        // raster position; frame end clears the count
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            if (row_pos + 1 >= h) begin
                row_pos = 0;
                del_total = '0;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
    endtask

    task automatic check_result();
        thin_result_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, new_value %0d deleted %0d count %0d last %0d",
                     $time, m_new_value, m_deleted, m_deleted_count, m_last);
            error_count++;
        end else begin
            want = pending_results.pop_front();
            if (m_new_value !== want.value) begin
                $display("%0t: new_value expected %0d, got %0d", $time, want.value, m_new_value);
                error_count++;
            end
            if (m_deleted !== want.deleted) begin
                $display("%0t: deleted expected %0d, got %0d", $time, want.deleted, m_deleted);
                error_count++;
            end
            if (m_deleted_count !== want.count) begin
                $display("%0t: deleted_count expected %0d, got %0d",
                         $time, want.count, m_deleted_count);
                error_count++;
            end
            if (m_last !== want.last) begin
                $display("%0t: last expected %0d, got %0d", $time, want.last, m_last);
                error_count++;
            end
        end
    endtask

    // Monitor: register writes, accepted pixels and accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == btp_pkg::REG_IMAGE_WIDTH)
                    width_reg = cfg_data[btp_pkg::WIDTH_W-1:0];
                else if (cfg_index == btp_pkg::REG_IMAGE_HEIGHT)
                    height_reg = cfg_data[btp_pkg::HEIGHT_W-1:0];
            end
            if (s_valid && s_ready) thin_pixel(s_pixel);
            if (m_valid && m_ready) check_result();
        end
    end

    // Result side backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // One pixel item; valid stays up after acceptance unless the next call idles
    task automatic send_pixel(input logic [PW-1:0] px);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One register write; call only while no item is in flight
    task automatic write_reg(input logic [CIW-1:0] reg_index,
                             input logic [CDW-1:0] reg_data);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data <= reg_data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_geometry(input logic [CDW-1:0] width_data,
                                input logic [CDW-1:0] height_data);
        wait_idle();
        write_reg(btp_pkg::REG_IMAGE_WIDTH, width_data);
        write_reg(btp_pkg::REG_IMAGE_HEIGHT, height_data);
    endtask

    // 3x3 frame, first pixel in the top byte
    task automatic send_window(input logic [9*PW-1:0] pix);
        for (int i = 8; i >= 0; i--) send_pixel(pix[i*PW +: PW]);
    endtask

    // Whole rows of random pixels at the current width
    task automatic send_rows(input int unsigned nrows);
        int unsigned   w;
        logic [PW-1:0] px;
        w = eff_width();
        for (int r = 0; r < nrows; r++) begin
            for (int c = 0; c < w; c++) begin
                if ($urandom_range(99) < 50) px = FULL;
                else px = PW'($urandom_range(255));
                send_pixel(px);
            end
        end
    endtask

    // One whole frame at the current geometry
    task automatic run_frame(input frame_kind_t kind);
        int unsigned   w;
        int unsigned   h;
        int unsigned   nrect;
        int unsigned   rx0 [4];
        int unsigned   rx1 [4];
        int unsigned   ry0 [4];
        int unsigned   ry1 [4];
        logic          hit;
        logic [PW-1:0] px;
        w = eff_width();
        h = eff_height();
        // solid blobs of 255 give edges that thin away
        nrect = $urandom_range(1, 4);
        for (int k = 0; k < 4; k++) begin
            rx0[k] = $urandom_range(w - 1);
            rx1[k] = rx0[k] + $urandom_range(2, w / 2 + 2);
            ry0[k] = $urandom_range(h - 1);
            ry1[k] = ry0[k] + $urandom_range(1, h / 2 + 1);
        end
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                case (kind)
                    FRAME_SHAPES: begin
                        hit = 1'b0;
                        for (int k = 0; k < nrect; k++) begin
                            if (c >= rx0[k] && c <= rx1[k] && r >= ry0[k] && r <= ry1[k])
                                hit = 1'b1;
                        end
                        px = hit ? FULL : '0;
                        if ($urandom_range(99) < 3) px = PW'($urandom_range(255));
                    end
                    FRAME_SPARSE: begin
                        if ($urandom_range(99) < 40) px = FULL;
                        else if ($urandom_range(99) < 8) px = PW'($urandom_range(1, 254));
                        else px = '0;
                    end
                    default: begin
                        px = PW'($urandom_range(255));
                    end
                endcase
                send_pixel(px);
            end
        end
    endtask

    // Geometry straight out of reset: one row at the reset width, then the
    // rest of the reset height at the narrowest width
    task automatic test_reset_geometry();
        send_rows(1);
        wait_idle();
        write_reg(btp_pkg::REG_IMAGE_WIDTH, CDW'(btp_pkg::MIN_DIM));
        send_rows(eff_height() - 1);
    endtask

    // Smallest frame: a thin arm that goes, a 254 center that stays, a full ring, a corner block
    task automatic test_corner_frames();
        set_geometry(12'd1, 12'd0);
        send_window({8'd0, 8'd128, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
        send_window({8'd0, 8'd128, 8'd255, 8'd0, 8'd254, 8'd0, 8'd0, 8'd0, 8'd0});
        send_window({8'd1, 8'd1, 8'd1, 8'd1, 8'd255, 8'd1, 8'd1, 8'd1, 8'd1});
        set_geometry(12'd2, 12'd2);
        send_window({8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
    endtask

    // Back to back frames with no idling on either side
    task automatic test_steady_stream();
        set_geometry(12'd8, 12'd6);
        steady = 1'b1;
        run_frame(FRAME_SHAPES);
        run_frame(FRAME_SPARSE);
        steady = 1'b0;
    endtask

    task automatic test_random_frames();
        int unsigned    start;
        int unsigned    sel;
        logic [CDW-1:0] wd;
        logic [CDW-1:0] hd;
        frame_kind_t    kind;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_ITEMS) begin
            // some frames keep the previous geometry and stream straight on
            if ($urandom_range(99) < 70) begin
                sel = $urandom_range(19);
                wd = (sel < btp_pkg::MIN_DIM) ? CDW'(sel) : CDW'($urandom_range(3, 8));
                sel = $urandom_range(19);
                hd = (sel < btp_pkg::MIN_DIM) ? CDW'(sel) : CDW'($urandom_range(3, 6));
                set_geometry(wd, hd);
            end
            sel = $urandom_range(99);
            if (sel < 60) kind = FRAME_SHAPES;
            else if (sel < 85) kind = FRAME_SPARSE;
            else kind = FRAME_NOISE;
            run_frame(kind);
        end
    endtask

    // Width field all ones, clamped: one full-width row, then narrow rows
    task automatic test_widest_row();
        set_geometry(12'hFFF, 12'd3);
        send_rows(1);
        wait_idle();
        write_reg(btp_pkg::REG_IMAGE_WIDTH, CDW'(btp_pkg::MIN_DIM));
        send_rows(2);
    endtask

    initial begin
        foreach (line_mem[i]) line_mem[i] = '0;
        foreach (win[i, j]) win[i][j] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_geometry();
        test_corner_frames();
        test_steady_stream();
        test_random_frames();
        test_widest_row();
        wait_idle();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
